// ----- rtl/sobel_pkg.sv -----
`default_nettype none

package sobel_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W     = 8;
   localparam int CFG_W     = 11;
   localparam int DIM_W     = CFG_W;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int POS_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W     = PIX_W + 2;
   localparam int MAG_W     = SUM_W + 1;
   localparam int LINE_W    = 2 * PIX_W;

   localparam logic [CFG_W-1:0] LINE_WIDTH_RST     = CFG_W'(160);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST   = CFG_W'(120);
   localparam logic [CFG_W-1:0] EDGE_THRESHOLD_RST = CFG_W'(150);
   localparam logic [DIM_W-1:0] MIN_DIM            = DIM_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH     = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             shift;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } grad_in_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = DIM_W'(v);
      if (r < MIN_DIM) begin
         r = MIN_DIM;
      end else if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sobel_if.sv -----
`default_nettype none

interface sobel_req_if import sobel_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sobel_rsp_if import sobel_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             edge_res;
   logic [POS_W-1:0] center_row;
   logic [POS_W-1:0] center_col;
   logic             frame_end;

   modport source (output valid, output edge_res, output center_row, output center_col,
                   output frame_end, input ready);
   modport sink (input valid, input edge_res, input center_row, input center_col,
                 input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/sobel_edge_threshold_top.sv -----
// a result for (r,c) is registered when stage 1 holding pixel (r+1,c+1) advances
// one request per cycle unless rsp_ch stalls; the line store is read at accept,
// written as stage 1 advances; a same-cycle write to the read column is forwarded
// reset: synchronous, clears counters, pipeline valids and registers to defaults;
// the line store is not cleared and needs no clearing pass
`default_nettype none

module sobel_edge_threshold_top import sobel_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   sobel_req_if.sink                 req_ch,
   sobel_rsp_if.source               rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   logic [CFG_W-1:0] line_width_ff, frame_height_ff, edge_threshold_ff;
   logic [DIM_W-1:0] w, h;

   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic [DIM_W-1:0] col_inc, row_inc;
   logic             emit, last, accept;

   logic              s1_valid_ff, s1_emit_ff, s1_last_ff, s1_fwd_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [LINE_W-1:0] s1_fwd_data_ff;
   logic              s1_advance;

   logic [LINE_W-1:0] ram_rdata, line_q, wr_data;
   grad_in_type       grad_in;
   logic              edge_res;

   logic             rsp_valid_ff, rsp_edge_ff, rsp_fend_ff;
   logic [POS_W-1:0] rsp_row_ff, rsp_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff     <= LINE_WIDTH_RST;
         frame_height_ff   <= FRAME_HEIGHT_RST;
         edge_threshold_ff <= EDGE_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:     line_width_ff     <= csr_wdata;
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            CSR_EDGE_THRESHOLD: edge_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w = clamp_dim(line_width_ff, DIM_W'(MAX_WIDTH));
   assign h = clamp_dim(frame_height_ff, DIM_W'(MAX_HEIGHT));

   // position of the incoming pixel and where the counters go next
   always_comb begin
      col_cur = req_ch.frame_start ? '0 : col_ff;
      row_cur = req_ch.frame_start ? '0 : row_ff;
      col_inc = DIM_W'(col_cur) + 1'b1;
      row_inc = DIM_W'(row_cur) + 1'b1;
      col_in  = col_inc[COL_W-1:0];
      row_in  = row_cur;
      if (col_inc >= w) begin
         col_in = '0;
         row_in = (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
      end
      emit = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2)) &&
             (DIM_W'(row_cur) < h) && (DIM_W'(col_cur) < w);
      last = (DIM_W'(row_cur) == h - 1'b1) && (DIM_W'(col_cur) == w - 1'b1);
   end

   assign s1_advance = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !reset && (!s1_valid_ff || s1_advance);
   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff     <= emit;
         s1_last_ff     <= last;
         s1_col_ff      <= col_cur;
         s1_row_ff      <= row_cur;
         s1_pix_ff      <= req_ch.pixel;
         // write-back to the same column in the read cycle is not seen by the ram
         s1_fwd_ff      <= s1_advance && (s1_col_ff == col_cur);
         s1_fwd_data_ff <= wr_data;
      end
   end

   assign line_q  = s1_fwd_ff ? s1_fwd_data_ff : ram_rdata;
   // older row gets the newer row, newer row gets the current pixel
   assign wr_data = {line_q[PIX_W-1:0], s1_pix_ff};

   sobel_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_rdata)
   );

   always_comb begin
      grad_in.shift = s1_advance;
      grad_in.top   = line_q[LINE_W-1:PIX_W];
      grad_in.mid   = line_q[PIX_W-1:0];
      grad_in.bot   = s1_pix_ff;
   end

   sobel_grad u_grad (
      .clock     (clock),
      .grad_in   (grad_in),
      .threshold (edge_threshold_ff),
      .edge_res  (edge_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_emit_ff) begin
         rsp_edge_ff <= edge_res;
         rsp_row_ff  <= POS_W'(s1_row_ff - 1'b1);
         rsp_col_ff  <= POS_W'(s1_col_ff - 1'b1);
         rsp_fend_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.edge_res   = rsp_edge_ff;
   assign rsp_ch.center_row = rsp_row_ff;
   assign rsp_ch.center_col = rsp_col_ff;
   assign rsp_ch.frame_end  = rsp_fend_ff;

endmodule

`default_nettype wire

// ----- rtl/sobel_ram.sv -----
`default_nettype none

module sobel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sobel_grad.sv -----
`default_nettype none

module sobel_grad import sobel_pkg::*; (
   input  wire logic              clock,
   input  wire grad_in_type       grad_in,
   input  wire logic [CFG_W-1:0]  threshold,
   output logic                   edge_res
);

   // 0..2: left column (top, mid, bottom), 3..5: middle column
   logic [PIX_W-1:0] win_ff [6];

   logic [SUM_W-1:0] gxp, gxn, gyp, gyn, dx, dy;
   logic [MAG_W-1:0] mag;

   always_ff @(posedge clock) begin
      if (grad_in.shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= grad_in.top;
         win_ff[4] <= grad_in.mid;
         win_ff[5] <= grad_in.bot;
      end
   end

   always_comb begin
      gxp = SUM_W'(grad_in.top) + {1'b0, grad_in.mid, 1'b0} + SUM_W'(grad_in.bot);
      gxn = SUM_W'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + SUM_W'(win_ff[2]);
      gyp = SUM_W'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + SUM_W'(grad_in.bot);
      gyn = SUM_W'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + SUM_W'(grad_in.top);
      dx  = (gxp > gxn) ? (gxp - gxn) : (gxn - gxp);
      dy  = (gyp > gyn) ? (gyp - gyn) : (gyn - gyp);
      mag = MAG_W'(dx) + MAG_W'(dy);
      edge_res = (MAG_W'(mag) > MAG_W'(threshold));
   end

endmodule

`default_nettype wire

// ----- rtl/sobel_chk.sv -----
`default_nettype none

module sobel_chk import sobel_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_edge_res,
   input wire logic [POS_W-1:0] rsp_center_row,
   input wire logic [POS_W-1:0] rsp_center_col,
   input wire logic             rsp_frame_end
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a fresh response comes from an accepted request via stage 1 and the response register
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without matching request");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_row != '0) && (rsp_center_col != '0))
      else $error("border pixel reported");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_edge_res, rsp_center_row, rsp_center_col, rsp_frame_end}))
      else $error("stalled response changed");

endmodule

bind sobel_edge_threshold_top sobel_chk u_sobel_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_edge_res   (rsp_ch.edge_res),
   .rsp_center_row (rsp_ch.center_row),
   .rsp_center_col (rsp_ch.center_col),
   .rsp_frame_end  (rsp_ch.frame_end)
);

`default_nettype wire
